// ----- design/caf_pkg.sv -----
// ----------------------------------------------------------------------------
// caf_pkg
// Shared opcodes, flag and item types for the cpu alu with flags block.
// ----------------------------------------------------------------------------
package caf_pkg;

  typedef enum logic [4:0] {
    OP_LD    = 5'd0,
    OP_INC   = 5'd1,
    OP_DEC   = 5'd2,
    OP_ADD   = 5'd3,
    OP_ADC   = 5'd4,
    OP_SUB   = 5'd5,
    OP_SBC   = 5'd6,
    OP_AND   = 5'd7,
    OP_OR    = 5'd8,
    OP_XOR   = 5'd9,
    OP_CP    = 5'd10,
    OP_SWAP  = 5'd11,
    OP_RLC   = 5'd12,
    OP_RL    = 5'd13,
    OP_RRC   = 5'd14,
    OP_RR    = 5'd15,
    OP_SLA   = 5'd16,
    OP_SRA   = 5'd17,
    OP_SRL   = 5'd18,
    OP_BIT   = 5'd19,
    OP_SET   = 5'd20,
    OP_RES   = 5'd21,
    OP_CCF   = 5'd22,
    OP_SCF   = 5'd23,
    OP_CPL   = 5'd24,
    OP_RLCA  = 5'd25,
    OP_RRCA  = 5'd26,
    OP_RRA   = 5'd27,
    OP_ADD16 = 5'd28,
    OP_INC16 = 5'd29,
    OP_DEC16 = 5'd30,
    OP_NOP   = 5'd31
  } alu_op_t;

  typedef struct packed {
    logic zero;
    logic sub;
    logic half;
    logic carry;
  } flags_t;

  typedef struct packed {
    alu_op_t     opcode;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    flags_t      flags;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] result;
    flags_t      flags;
  } alu_rsp_t;

endpackage

// ----- design/caf_exec.sv -----
// ----------------------------------------------------------------------------
// caf_exec
// Single-pass alu datapath: computes result and new flags from one request.
// ----------------------------------------------------------------------------
module caf_exec
  import caf_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic        t;
  logic [8:0]  sum8;
  logic [4:0]  sum4;
  logic [8:0]  dif8;
  logic [4:0]  dif4;
  logic [16:0] sum16;
  logic [12:0] sum12;
  logic [7:0]  mask;
  logic [7:0]  r8;
  logic        sc;

  assign a    = req.operand_a[7:0];
  assign b    = req.operand_b[7:0];
  assign cin  = req.flags.carry;
  assign t    = ((req.opcode == OP_ADC) || (req.opcode == OP_SBC)) ? cin : 1'b0;
  assign sum8 = {1'b0, a} + {1'b0, b} + {8'd0, t};
  assign sum4 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
  assign dif8 = {1'b0, a} - {1'b0, b} - {8'd0, t};
  assign dif4 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
  assign sum16 = {1'b0, req.operand_a} + {1'b0, req.operand_b};
  assign sum12 = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
  assign mask  = 8'd1 << req.bit_index;

  // shift and rotate unit
  always_comb begin
    r8 = {a[0], a[7:1]};
    sc = a[0];
    case (req.opcode)
      OP_RLC, OP_RLCA: begin
        r8 = {a[6:0], a[7]};
        sc = a[7];
      end
      OP_RL: begin
        r8 = {a[6:0], cin};
        sc = a[7];
      end
      OP_RRC, OP_RRCA: begin
        r8 = {a[0], a[7:1]};
        sc = a[0];
      end
      OP_RR, OP_RRA: begin
        r8 = {cin, a[7:1]};
        sc = a[0];
      end
      OP_SLA: begin
        r8 = {a[6:0], 1'b0};
        sc = a[7];
      end
      OP_SRA: begin
        r8 = {a[7], a[7:1]};
        sc = a[0];
      end
      OP_SRL: begin
        r8 = {1'b0, a[7:1]};
        sc = a[0];
      end
      default: begin
        r8 = {a[0], a[7:1]};
        sc = a[0];
      end
    endcase
  end

  always_comb begin
    rsp.result = req.operand_a;
    rsp.flags  = req.flags;
    case (req.opcode)
      OP_LD: begin
        rsp.result = req.operand_b;
      end
      OP_INC: begin
        rsp.result     = {8'd0, a + 8'd1};
        rsp.flags.zero = (a == 8'hff);
        rsp.flags.sub  = 1'b0;
        rsp.flags.half = (a[3:0] == 4'hf);
      end
      OP_DEC: begin
        rsp.result     = {8'd0, a - 8'd1};
        rsp.flags.zero = (a == 8'h01);
        rsp.flags.sub  = 1'b1;
        rsp.flags.half = (a[3:0] == 4'h0);
      end
      OP_ADD, OP_ADC: begin
        rsp.result      = {8'd0, sum8[7:0]};
        rsp.flags.zero  = (sum8[7:0] == 8'd0);
        rsp.flags.sub   = 1'b0;
        rsp.flags.half  = sum4[4];
        rsp.flags.carry = sum8[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        rsp.result      = (req.opcode == OP_CP) ? {8'd0, a} : {8'd0, dif8[7:0]};
        rsp.flags.zero  = (dif8[7:0] == 8'd0);
        rsp.flags.sub   = 1'b1;
        rsp.flags.half  = dif4[4];
        rsp.flags.carry = dif8[8];
      end
      OP_AND: begin
        rsp.result = {8'd0, a & b};
        rsp.flags  = '{zero: ((a & b) == 8'd0), sub: 1'b0, half: 1'b1, carry: 1'b0};
      end
      OP_OR: begin
        rsp.result = {8'd0, a | b};
        rsp.flags  = '{zero: ((a | b) == 8'd0), sub: 1'b0, half: 1'b0, carry: 1'b0};
      end
      OP_XOR: begin
        rsp.result = {8'd0, a ^ b};
        rsp.flags  = '{zero: ((a ^ b) == 8'd0), sub: 1'b0, half: 1'b0, carry: 1'b0};
      end
      OP_SWAP: begin
        rsp.result = {8'd0, a[3:0], a[7:4]};
        rsp.flags  = '{zero: (a == 8'd0), sub: 1'b0, half: 1'b0, carry: 1'b0};
      end
      OP_RLC, OP_RL, OP_RRC, OP_RR, OP_SLA, OP_SRA, OP_SRL: begin
        rsp.result = {8'd0, r8};
        rsp.flags  = '{zero: (r8 == 8'd0), sub: 1'b0, half: 1'b0, carry: sc};
      end
      OP_RLCA, OP_RRCA, OP_RRA: begin
        rsp.result = {8'd0, r8};
        rsp.flags  = '{zero: 1'b0, sub: 1'b0, half: 1'b0, carry: sc};
      end
      OP_BIT: begin
        rsp.result     = {8'd0, a};
        rsp.flags.zero = ((a & mask) == 8'd0);
        rsp.flags.sub  = 1'b0;
        rsp.flags.half = 1'b1;
      end
      OP_SET: begin
        rsp.result = {8'd0, a | mask};
      end
      OP_RES: begin
        rsp.result = {8'd0, a & ~mask};
      end
      OP_CCF: begin
        rsp.result      = {8'd0, a};
        rsp.flags.sub   = 1'b0;
        rsp.flags.half  = 1'b0;
        rsp.flags.carry = ~cin;
      end
      OP_SCF: begin
        rsp.result      = {8'd0, a};
        rsp.flags.sub   = 1'b0;
        rsp.flags.half  = 1'b0;
        rsp.flags.carry = 1'b1;
      end
      OP_CPL: begin
        rsp.result     = {8'd0, ~a};
        rsp.flags.sub  = 1'b1;
        rsp.flags.half = 1'b1;
      end
      OP_ADD16: begin
        rsp.result      = sum16[15:0];
        rsp.flags.sub   = 1'b0;
        rsp.flags.half  = sum12[12];
        rsp.flags.carry = sum16[16];
      end
      OP_INC16: begin
        rsp.result = req.operand_a + 16'd1;
      end
      OP_DEC16: begin
        rsp.result = req.operand_a - 16'd1;
      end
      default: begin
        rsp.result = req.operand_a;
      end
    endcase
  end

endmodule

// ----- design/cpu_alu_with_flags_core.sv -----
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_core
// 8/16-bit cpu alu with zero, subtract, half-carry and carry flags.
//
// usage:
//   request channel (req_valid/req_ready) carries opcode, both operands,
//   the bit index and the four incoming flags.
//   response channel (rsp_valid/rsp_ready) carries the result and new flags,
//   one response per request, in request order.
//   a request reaches the response through an input register, the
//   alu datapath, then a result register.
//   throughput is one request per cycle while rsp_ready stays high.
//   reset clears both stage valid bits; req_ready is high right after reset.
//   when the receiver stalls, the response holds and one more request is
//   taken into the input register; req_ready then drops until the result
//   register drains.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags_core
  import caf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [4:0]  opcode,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic [2:0]  bit_index,
  input  logic        zero_in,
  input  logic        sub_in,
  input  logic        half_in,
  input  logic        carry_in,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [15:0] result,
  output logic        zero_out,
  output logic        sub_out,
  output logic        half_out,
  output logic        carry_out
);

  logic     s1_valid;
  alu_req_t s1_req;
  alu_rsp_t exec_rsp;
  alu_rsp_t rsp;
  logic     s2_ready;

  assign s2_ready  = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || s2_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      s1_req.opcode    <= alu_op_t'(opcode);
      s1_req.operand_a <= operand_a;
      s1_req.operand_b <= operand_b;
      s1_req.bit_index <= bit_index;
      s1_req.flags     <= '{zero: zero_in, sub: sub_in, half: half_in, carry: carry_in};
    end
  end

  caf_exec u_exec (
    .req (s1_req),
    .rsp (exec_rsp)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s2_ready) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      rsp <= exec_rsp;
    end
  end

  assign result    = rsp.result;
  assign zero_out  = rsp.flags.zero;
  assign sub_out   = rsp.flags.sub;
  assign half_out  = rsp.flags.half;
  assign carry_out = rsp.flags.carry;

endmodule

// ----- design/caf_checker.sv -----
// ----------------------------------------------------------------------------
// caf_checker
// Port-level checks for the cpu alu with flags block, bound to the top level.
// ----------------------------------------------------------------------------
module caf_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] result,
  input logic        zero_out,
  input logic        sub_out,
  input logic        half_out,
  input logic        carry_out
);

  // no response right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // an empty result register never blocks a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request blocked while result register empty");

  // stalled response stays valid
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // stalled response payload is stable
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(result) && $stable(zero_out) &&
      $stable(sub_out) && $stable(half_out) && $stable(carry_out))
    else $error("response payload changed while stalled");

endmodule

bind cpu_alu_with_flags_core caf_checker u_caf_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .result    (result),
  .zero_out  (zero_out),
  .sub_out   (sub_out),
  .half_out  (half_out),
  .carry_out (carry_out)
);

// ----- verif/tb_cpu_alu_with_flags_core.sv -----
// ----------------------------------------------------------------------------
// tb_cpu_alu_with_flags_core
// Self-checking bench for the 8/16-bit alu with zero/sub/half/carry flags.
// Every opcode is applied with extreme operands, then flag borders (half and
// full carry, borrow, bit test, 16-bit wrap), then long random traffic with
// random idle gaps and receiver stalls. Each accepted request is run through
// a local model of the alu and each response is compared field by field.
// ----------------------------------------------------------------------------
module tb_cpu_alu_with_flags_core;
  import caf_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_REQUESTS = 1700;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [4:0]  opcode = '0;
  logic [15:0] operand_a = '0;
  logic [15:0] operand_b = '0;
  logic [2:0]  bit_index = '0;
  logic        zero_in = 1'b0;
  logic        sub_in = 1'b0;
  logic        half_in = 1'b0;
  logic        carry_in = 1'b0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [15:0] result;
  logic        zero_out;
  logic        sub_out;
  logic        half_out;
  logic        carry_out;

  alu_rsp_t predicted_alu_out[$];
  int       mismatch_count = 0;
  int       quiet_cycles = 0;
  int       rsp_stall = 0;
  logic     no_idle = 1'b0;

  cpu_alu_with_flags_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .opcode    (opcode),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .bit_index (bit_index),
    .zero_in   (zero_in),
    .sub_in    (sub_in),
    .half_in   (half_in),
    .carry_in  (carry_in),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .result    (result),
    .zero_out  (zero_out),
    .sub_out   (sub_out),
    .half_out  (half_out),
    .carry_out (carry_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic alu_rsp_t alu_eval(alu_req_t rq);
    alu_rsp_t   rs;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] r8;
    logic [8:0] wide8;
    logic [4:0] nib;
    logic [12:0] wide12;
    logic [16:0] wide16;
    logic       t;
    logic       shifted_out;
    a = rq.operand_a[7:0];
    b = rq.operand_b[7:0];
    rs.result = rq.operand_a;
    rs.flags = rq.flags;
    case (rq.opcode)
      OP_LD: rs.result = rq.operand_b;
      OP_INC: begin
        r8 = a + 8'd1;
        rs.result = {8'h00, r8};
        rs.flags.zero = (r8 == 8'h00);
        rs.flags.sub = 1'b0;
        rs.flags.half = (a[3:0] == 4'hf);
      end
      OP_DEC: begin
        r8 = a - 8'd1;
        rs.result = {8'h00, r8};
        rs.flags.zero = (r8 == 8'h00);
        rs.flags.sub = 1'b1;
        rs.flags.half = (a[3:0] == 4'h0);
      end
      OP_ADD, OP_ADC: begin
        t = (rq.opcode == OP_ADC) ? rq.flags.carry : 1'b0;
        nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, t};
        wide8 = {1'b0, a} + {1'b0, b} + {8'h00, t};
        rs.result = {8'h00, wide8[7:0]};
        rs.flags.zero = (wide8[7:0] == 8'h00);
        rs.flags.sub = 1'b0;
        rs.flags.half = nib[4];
        rs.flags.carry = wide8[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        t = (rq.opcode == OP_SBC) ? rq.flags.carry : 1'b0;
        nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, t};
        wide8 = {1'b0, a} - {1'b0, b} - {8'h00, t};
        rs.result = (rq.opcode == OP_CP) ? {8'h00, a} : {8'h00, wide8[7:0]};
        rs.flags.zero = (wide8[7:0] == 8'h00);
        rs.flags.sub = 1'b1;
        rs.flags.half = nib[4];
        rs.flags.carry = wide8[8];
      end
      OP_AND, OP_OR, OP_XOR, OP_SWAP: begin
        case (rq.opcode)
          OP_AND:  r8 = a & b;
          OP_OR:   r8 = a | b;
          OP_XOR:  r8 = a ^ b;
          default: r8 = {a[3:0], a[7:4]};
        endcase
        rs.result = {8'h00, r8};
        rs.flags.zero = (r8 == 8'h00);
        rs.flags.sub = 1'b0;
        rs.flags.half = (rq.opcode == OP_AND);
        rs.flags.carry = 1'b0;
      end
      OP_RLC, OP_RL, OP_RRC, OP_RR, OP_SLA, OP_SRA, OP_SRL, OP_RLCA, OP_RRCA, OP_RRA: begin
        case (rq.opcode)
          OP_RLC, OP_RLCA: begin r8 = {a[6:0], a[7]};            shifted_out = a[7]; end
          OP_RL:           begin r8 = {a[6:0], rq.flags.carry};  shifted_out = a[7]; end
          OP_RRC, OP_RRCA: begin r8 = {a[0], a[7:1]};            shifted_out = a[0]; end
          OP_RR, OP_RRA:   begin r8 = {rq.flags.carry, a[7:1]};  shifted_out = a[0]; end
          OP_SLA:          begin r8 = {a[6:0], 1'b0};            shifted_out = a[7]; end
          OP_SRA:          begin r8 = {a[7], a[7:1]};            shifted_out = a[0]; end
          default:         begin r8 = {1'b0, a[7:1]};            shifted_out = a[0]; end
        endcase
        rs.result = {8'h00, r8};
        // accumulator rotates always clear zero
        if (rq.opcode == OP_RLCA || rq.opcode == OP_RRCA || rq.opcode == OP_RRA) begin
          rs.flags.zero = 1'b0;
        end else begin
          rs.flags.zero = (r8 == 8'h00);
        end
        rs.flags.sub = 1'b0;
        rs.flags.half = 1'b0;
        rs.flags.carry = shifted_out;
      end
      OP_BIT: begin
        rs.result = {8'h00, a};
        rs.flags.zero = ~a[rq.bit_index];
        rs.flags.sub = 1'b0;
        rs.flags.half = 1'b1;
      end
      OP_SET, OP_RES: begin
        r8 = a;
        r8[rq.bit_index] = (rq.opcode == OP_SET);
        rs.result = {8'h00, r8};
      end
      OP_CCF, OP_SCF: begin
        rs.result = {8'h00, a};
        rs.flags.sub = 1'b0;
        rs.flags.half = 1'b0;
        rs.flags.carry = (rq.opcode == OP_SCF) ? 1'b1 : ~rq.flags.carry;
      end
      OP_CPL: begin
        rs.result = {8'h00, ~a};
        rs.flags.sub = 1'b1;
        rs.flags.half = 1'b1;
      end
      OP_ADD16: begin
        wide12 = {1'b0, rq.operand_a[11:0]} + {1'b0, rq.operand_b[11:0]};
        wide16 = {1'b0, rq.operand_a} + {1'b0, rq.operand_b};
        rs.result = wide16[15:0];
        rs.flags.sub = 1'b0;
        rs.flags.half = wide12[12];
        rs.flags.carry = wide16[16];
      end
      OP_INC16: rs.result = rq.operand_a + 16'd1;
      OP_DEC16: rs.result = rq.operand_a - 16'd1;
      default:  rs.result = rq.operand_a;
    endcase
    return rs;
  endfunction

  function automatic alu_req_t make_req(alu_op_t op, logic [15:0] a, logic [15:0] b,
                                        logic [2:0] idx, logic [3:0] flg);
    alu_req_t rq;
    rq.opcode = op;
    rq.operand_a = a;
    rq.operand_b = b;
    rq.bit_index = idx;
    rq.flags = flags_t'(flg);
    return rq;
  endfunction

  // half of the operands get a corner value in the low byte
  function automatic logic [15:0] pick_operand();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 11))
      0: v[7:0] = 8'h00;
      1: v[7:0] = 8'h0f;
      2: v[7:0] = 8'h10;
      3: v[7:0] = 8'hff;
      4: v[7:0] = 8'h7f;
      5: v[7:0] = 8'h80;
      default: ;
    endcase
    return v;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic issue_request(input alu_req_t rq);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode = rq.opcode;
    operand_a = rq.operand_a;
    operand_b = rq.operand_b;
    bit_index = rq.bit_index;
    {zero_in, sub_in, half_in, carry_in} = rq.flags;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    predicted_alu_out.push_back(alu_eval(rq));
    @(negedge clk);
  endtask

  task automatic test_every_opcode();
    logic [15:0] a;
    for (int i = 0; i < 32; i++) begin
      a = i[0] ? 16'hffff : 16'h0000;
      issue_request(make_req(alu_op_t'(i), a, ~a, 3'(i), 4'(i)));
    end
  endtask

  task automatic test_flag_boundaries();
    issue_request(make_req(OP_ADD,   16'h000f, 16'h0001, 3'd0, 4'b0000));
    issue_request(make_req(OP_ADD,   16'h00ff, 16'h0001, 3'd0, 4'b0000));
    issue_request(make_req(OP_ADC,   16'h000f, 16'h0000, 3'd0, 4'b0001));
    issue_request(make_req(OP_ADC,   16'h00ff, 16'h0000, 3'd0, 4'b0001));
    issue_request(make_req(OP_SBC,   16'h0010, 16'h000f, 3'd0, 4'b0001));
    issue_request(make_req(OP_SBC,   16'h0000, 16'h00ff, 3'd0, 4'b0001));
    issue_request(make_req(OP_CP,    16'h123c, 16'hab3c, 3'd0, 4'b0000));
    issue_request(make_req(OP_INC,   16'h00ff, 16'h0000, 3'd0, 4'b0100));
    issue_request(make_req(OP_DEC,   16'h0001, 16'h0000, 3'd0, 4'b0000));
    issue_request(make_req(OP_BIT,   16'h0080, 16'h0000, 3'd7, 4'b0000));
    issue_request(make_req(OP_BIT,   16'h007f, 16'h0000, 3'd7, 4'b0001));
    issue_request(make_req(OP_ADD16, 16'h0fff, 16'h0001, 3'd0, 4'b1000));
    issue_request(make_req(OP_ADD16, 16'hffff, 16'h0001, 3'd0, 4'b0000));
    issue_request(make_req(OP_INC16, 16'hffff, 16'h0000, 3'd0, 4'b1111));
    issue_request(make_req(OP_DEC16, 16'h0000, 16'h0000, 3'd0, 4'b0000));
    issue_request(make_req(OP_SRA,   16'h0081, 16'h0000, 3'd0, 4'b0000));
    issue_request(make_req(OP_RLCA,  16'h0000, 16'h0000, 3'd0, 4'b1000));
    issue_request(make_req(OP_LD,    16'h1234, 16'hbeef, 3'd0, 4'b1010));
  endtask

  task automatic test_random_traffic(input int n_requests);
    for (int i = 0; i < n_requests; i++) begin
      // every so often a burst with no gaps on either side
      if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      issue_request(make_req(alu_op_t'($urandom_range(0, 31)), pick_operand(), pick_operand(),
                             3'($urandom_range(0, 7)), 4'($urandom_range(0, 15))));
    end
    no_idle = 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : rsp_check
    alu_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (predicted_alu_out.size() == 0) begin
        $error("response with no request outstanding: result %h", result);
        mismatch_count++;
      end else begin
        want = predicted_alu_out.pop_front();
        compare_field("result", want.result, result);
        compare_field("zero_out", 16'(want.flags.zero), 16'(zero_out));
        compare_field("sub_out", 16'(want.flags.sub), 16'(sub_out));
        compare_field("half_out", 16'(want.flags.half), 16'(half_out));
        compare_field("carry_out", 16'(want.flags.carry), 16'(carry_out));
      end
      rsp_stall = no_idle ? 0 : $urandom_range(0, 5);
    end
  end

  always @(negedge clk) begin
    if (rsp_stall > 0) begin
      rsp_ready = 1'b0;
      rsp_stall--;
    end else begin
      rsp_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_every_opcode();
    test_flag_boundaries();
    test_random_traffic(RANDOM_REQUESTS);
    req_valid = 1'b0;
    while (predicted_alu_out.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
